// File: hdl/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types and constants for the RTP header parser: status codes,
// record kinds, the event carried from front to back, and the output record.
// ----------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

  localparam int unsigned POSITION_BITS_DEF = 20;
  localparam int unsigned FIXED_HDR_BYTES   = 12;
  localparam int unsigned EXT_HDR_BYTES     = 4;
  localparam int unsigned HSIZE_W           = 19;
  localparam int unsigned QUEUE_DEPTH       = 4;
  localparam logic [1:0]  RTP_VERSION       = 2'd2;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_SHORT         = 3'd1,
    ST_BAD_VER       = 3'd2,
    ST_SHORT_CSRC    = 3'd3,
    ST_SHORT_EXT_HDR = 3'd4,
    ST_SHORT_EXT_DAT = 3'd5
  } status_e;

  typedef enum logic {
    KIND_CSRC    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  // One accepted byte that produced at least one record.
  typedef struct packed {
    logic                 csrc_vld;
    logic                 sum_vld;
    logic [2:0]           flags;
    logic [3:0]           csrc_count;
    logic [6:0]           payload_type;
    logic [15:0]          seq;
    logic [31:0]          ts;
    logic [31:0]          ssrc;
    logic [31:0]          csrc_word;
    logic [3:0]           slot;
    status_e              status;
    logic [31:0]          sum_aux;
    logic [HSIZE_W-1:0]   hsize;
    logic [7:0]           pad_len;
  } evt_t;

  typedef struct packed {
    kind_e                kind;
    status_e              status;
    logic [2:0]           flags;
    logic [3:0]           csrc_count;
    logic [6:0]           payload_type;
    logic [15:0]          seq;
    logic [31:0]          ts;
    logic [31:0]          ssrc;
    logic [31:0]          aux;
    logic [3:0]           slot;
    logic [HSIZE_W-1:0]   hsize;
    logic [7:0]           pad_len;
  } rec_t;

endpackage

`default_nettype wire

// File: hdl/rhp_front.sv
// ----------------------------------------------------------------------------
// rhp_front
// Byte intake: counts bytes, holds the fixed header, assembles CSRC and
// extension words, and builds one event per byte that yields records.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_front #(
  parameter int unsigned POSITION_BITS = rhp_pkg::POSITION_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output rhp_pkg::evt_t         evt_o
);

  localparam int unsigned HW   = rhp_pkg::HSIZE_W;
  localparam int unsigned CmpW = ((POSITION_BITS > HW) ? POSITION_BITS : HW) + 1;
  localparam logic [POSITION_BITS-1:0] PosMax = '1;

  logic [POSITION_BITS-1:0] pos_q;
  logic [7:0]               hdr_q [rhp_pkg::FIXED_HDR_BYTES];
  logic [7:0]               hdr_d [rhp_pkg::FIXED_HDR_BYTES];
  logic [31:0]              word_q, word_d;
  logic [31:0]              extw_q, extw_d;
  logic [HW-1:0]            ext_end_q, ext_end_d;

  logic                     accept;
  logic                     ver_ok, ext, pad;
  logic [3:0]               cc;
  logic [6:0]               csrc_end;
  logic [CmpW-1:0]          pos_w, len_w, csrc_end_w, ext_hdr_end_w;
  logic                     past_fixed, in_csrc, in_exth, csrc_done, exth_done;
  rhp_pkg::status_e         status;
  logic [HW-1:0]            hsize;
  logic [31:0]              sum_aux;
  logic [7:0]               pad_len;
  logic                     hdr_ok;

  always_comb begin
    accept = in_valid_i && !q_full_i;

    hdr_d = hdr_q;
    if (pos_q < POSITION_BITS'(rhp_pkg::FIXED_HDR_BYTES)) begin
      hdr_d[pos_q[3:0]] = data_byte_i;
    end

    ver_ok   = (hdr_d[0][7:6] == rhp_pkg::RTP_VERSION);
    pad      = hdr_d[0][5];
    ext      = hdr_d[0][4];
    cc       = hdr_d[0][3:0];
    csrc_end = 7'(rhp_pkg::FIXED_HDR_BYTES) + {1'b0, cc, 2'b00};

    pos_w         = CmpW'(pos_q);
    csrc_end_w    = CmpW'(csrc_end);
    ext_hdr_end_w = csrc_end_w + CmpW'(rhp_pkg::EXT_HDR_BYTES);
    len_w         = (pos_q != PosMax) ? pos_w + CmpW'(1) : pos_w;

    past_fixed = (pos_w >= CmpW'(rhp_pkg::FIXED_HDR_BYTES));
    in_csrc    = past_fixed && ver_ok && (pos_w < csrc_end_w);
    in_exth    = past_fixed && ver_ok && !in_csrc && ext && (pos_w < ext_hdr_end_w);
    csrc_done  = in_csrc && (pos_q[1:0] == 2'b11);
    exth_done  = in_exth && (pos_w == ext_hdr_end_w - CmpW'(1));

    word_d    = (in_csrc || in_exth) ? {word_q[23:0], data_byte_i} : word_q;
    extw_d    = exth_done ? word_d : extw_q;
    ext_end_d = exth_done ?
                HW'(csrc_end) + HW'(rhp_pkg::EXT_HDR_BYTES) + {1'b0, word_d[15:0], 2'b00} :
                ext_end_q;

    // Summary of the packet, valid when this byte is the last one.
    status  = rhp_pkg::ST_OK;
    hsize   = HW'(rhp_pkg::FIXED_HDR_BYTES);
    sum_aux = '0;
    pad_len = '0;
    hdr_ok  = 1'b1;
    if (len_w < CmpW'(rhp_pkg::FIXED_HDR_BYTES)) begin
      status = rhp_pkg::ST_SHORT;
      hsize  = '0;
      hdr_ok = 1'b0;
    end else if (!ver_ok) begin
      status = rhp_pkg::ST_BAD_VER;
      hsize  = '0;
      hdr_ok = 1'b0;
    end else if (len_w < csrc_end_w) begin
      status = rhp_pkg::ST_SHORT_CSRC;
    end else begin
      hsize = HW'(csrc_end);
      if (ext) begin
        if (len_w < ext_hdr_end_w) begin
          status = rhp_pkg::ST_SHORT_EXT_HDR;
        end else begin
          sum_aux = extw_d;
          if (len_w < CmpW'(ext_end_d)) begin
            status = rhp_pkg::ST_SHORT_EXT_DAT;
            hsize  = HW'(csrc_end) + HW'(rhp_pkg::EXT_HDR_BYTES);
          end else begin
            hsize = ext_end_d;
          end
        end
      end
      if ((status == rhp_pkg::ST_OK) && pad) begin
        pad_len = data_byte_i;
      end
    end

    evt_o.csrc_vld     = csrc_done;
    evt_o.sum_vld      = last_byte_i;
    evt_o.csrc_word    = word_d;
    evt_o.slot         = pos_q[5:2] - 4'd3;
    evt_o.status       = status;
    evt_o.sum_aux      = sum_aux;
    evt_o.hsize        = hsize;
    evt_o.pad_len      = pad_len;
    if (last_byte_i && !hdr_ok) begin
      evt_o.flags        = '0;
      evt_o.csrc_count   = '0;
      evt_o.payload_type = '0;
      evt_o.seq          = '0;
      evt_o.ts           = '0;
      evt_o.ssrc         = '0;
    end else begin
      evt_o.flags        = {pad, ext, hdr_d[1][7]};
      evt_o.csrc_count   = cc;
      evt_o.payload_type = hdr_d[1][6:0];
      evt_o.seq          = {hdr_d[2], hdr_d[3]};
      evt_o.ts           = {hdr_d[4], hdr_d[5], hdr_d[6], hdr_d[7]};
      evt_o.ssrc         = {hdr_d[8], hdr_d[9], hdr_d[10], hdr_d[11]};
    end

    push_o     = accept && (csrc_done || last_byte_i);
    in_stall_o = q_full_i;
  end

  // Advance the position; restart on the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      word_q <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        word_q <= '0;
      end else begin
        word_q <= word_d;
        if (pos_q != PosMax) begin
          pos_q <= pos_q + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hdr_q     <= hdr_d;
      extw_q    <= extw_d;
      ext_end_q <= ext_end_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rhp_queue.sv
// ----------------------------------------------------------------------------
// rhp_queue
// Small FIFO of events between the byte intake and the record output.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  rhp_pkg::evt_t       evt_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output rhp_pkg::evt_t       head_o,
  output logic                empty_o
);

  localparam int unsigned Depth = rhp_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rhp_pkg::evt_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  always_comb begin
    full_o  = (cnt_q == CntW'(Depth));
    empty_o = (cnt_q == '0);
    do_push = push_i && !full_o;
    do_pop  = pop_i && !empty_o;
    head_o  = mem_q[rptr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= evt_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rhp_back.sv
// ----------------------------------------------------------------------------
// rhp_back
// Record output: unrolls each event into one or two records and holds them
// in an output register until the consumer takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  rhp_pkg::evt_t       head_i,
  input  wire logic           empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rhp_pkg::rec_t       rec_o
);

  logic          out_valid_q;
  logic          phase_q;
  rhp_pkg::rec_t rec_q, rec_d;
  logic          load, both, take_csrc;

  always_comb begin
    load      = !out_valid_q || !out_stall_i;
    both      = head_i.csrc_vld && head_i.sum_vld;
    take_csrc = head_i.csrc_vld && !phase_q;

    rec_d.flags        = head_i.flags;
    rec_d.csrc_count   = head_i.csrc_count;
    rec_d.payload_type = head_i.payload_type;
    rec_d.seq          = head_i.seq;
    rec_d.ts           = head_i.ts;
    rec_d.ssrc         = head_i.ssrc;
    if (take_csrc) begin
      rec_d.kind    = rhp_pkg::KIND_CSRC;
      rec_d.status  = rhp_pkg::ST_OK;
      rec_d.aux     = head_i.csrc_word;
      rec_d.slot    = head_i.slot;
      rec_d.hsize   = '0;
      rec_d.pad_len = '0;
    end else begin
      rec_d.kind    = rhp_pkg::KIND_SUMMARY;
      rec_d.status  = head_i.status;
      rec_d.aux     = head_i.sum_aux;
      rec_d.slot    = '0;
      rec_d.hsize   = head_i.hsize;
      rec_d.pad_len = head_i.pad_len;
    end

    // Hold the event while its CSRC record goes out first.
    pop_o       = load && !empty_i && !(both && !phase_q);
    out_valid_o = out_valid_q;
    rec_o       = rec_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      phase_q     <= !empty_i && both && !phase_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      rec_q <= rec_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/rtp_header_parser.sv
// ----------------------------------------------------------------------------
// rtp_header_parser
// RTP header decoder: one packet byte per beat in, CSRC and summary records out.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the event queue is not full. A byte yields
//   at most two records; the second follows the first and the event queue holds it.
// Path: the byte completing a record writes its event into the queue, and the
//   record is then loaded into the output register once the back is free.
// Reset: rst_ni clears the byte position, CSRC word, queue pointers and count, output
//   valid and phase at once; header and extension words need no clearing; no pass is run.
`default_nettype none

module rtp_header_parser #(
  // Width of the saturating byte position within a packet.
  parameter int unsigned POSITION_BITS = rhp_pkg::POSITION_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // Byte input channel
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire logic [7:0]   data_byte_i,
  input  wire logic         last_byte_i,
  // Record output channel
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic              record_kind_o,
  output logic [2:0]        status_o,
  output logic [2:0]        flag_bits_o,
  output logic [3:0]        csrc_count_o,
  output logic [6:0]        payload_type_o,
  output logic [15:0]       sequence_number_o,
  output logic [31:0]       time_stamp_o,
  output logic [31:0]       sync_source_o,
  output logic [31:0]       aux_word_o,
  output logic [3:0]        csrc_slot_o,
  output logic [18:0]       header_size_o,
  output logic [7:0]        padding_length_o
);

  rhp_pkg::evt_t q_wr_evt, q_head;
  rhp_pkg::rec_t rec;
  logic          q_push, q_full, q_pop, q_empty;

  // Front: take bytes, track position, decode the header, build events.
  rhp_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .evt_o       (q_wr_evt)
  );

  // Queue: decouple byte intake from record delivery.
  rhp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .evt_i   (q_wr_evt),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // Back: split events into records, hold each until its beat is taken.
  rhp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (rec)
  );

  assign record_kind_o     = rec.kind;
  assign status_o          = rec.status;
  assign flag_bits_o       = rec.flags;
  assign csrc_count_o      = rec.csrc_count;
  assign payload_type_o    = rec.payload_type;
  assign sequence_number_o = rec.seq;
  assign time_stamp_o      = rec.ts;
  assign sync_source_o     = rec.ssrc;
  assign aux_word_o        = rec.aux;
  assign csrc_slot_o       = rec.slot;
  assign header_size_o     = rec.hsize;
  assign padding_length_o  = rec.pad_len;

`ifndef SYNTH
  // The front never writes an event into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("event pushed into full queue");

  // A CSRC record carries no summary content.
  a_csrc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (record_kind_o == rhp_pkg::KIND_CSRC)) |->
    (status_o == rhp_pkg::ST_OK && header_size_o == '0 && padding_length_o == '0))
    else $error("CSRC record with summary fields set");

  // A short or bad-version summary carries no header content.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == rhp_pkg::ST_SHORT || status_o == rhp_pkg::ST_BAD_VER))
    |-> (flag_bits_o == '0 && header_size_o == '0 && sync_source_o == '0
         && aux_word_o == '0))
    else $error("rejected packet summary with header fields");

  // Padding length shows only on a clean summary with the padding flag.
  a_pad_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && padding_length_o != '0) |->
    (flag_bits_o[2] && status_o == rhp_pkg::ST_OK
     && record_kind_o == rhp_pkg::KIND_SUMMARY))
    else $error("padding length without padding flag");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for rtp_header_parser. Feeds whole RTP packets one byte
// per beat (directed corner packets, then a random mix of well-formed,
// truncated, wrong-version and junk packets, then a packet claiming the largest
// extension length), predicts every CSRC and summary record in a scoreboard
// class and compares each record leaving the block against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Run a 16-bit position counter.
  localparam int unsigned POS_BITS     = 16;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 1100;
  localparam int unsigned QUIET_PKTS   = 6;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef logic [7:0] packet_t [$];

  // --------------------------------------------------------------------------
  // Record scoreboard: tracks the parser state byte by byte and holds the
  // records it expects, oldest first.
  // --------------------------------------------------------------------------
  class rtp_record_scoreboard;
    int unsigned    pos_max;
    int unsigned    byte_pos;
    logic [7:0]     hdr_bytes [rhp_pkg::FIXED_HDR_BYTES];
    logic [31:0]    word_acc;
    logic [31:0]    ext_word;
    rhp_pkg::rec_t  expected_records [$];
    int unsigned    failures;

    function new(int unsigned pos_bits);
      pos_max  = (1 << pos_bits) - 1;
      failures = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos = 0;
      foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
      word_acc = '0;
      ext_word = '0;
    endfunction

    // Build a record; without the header every field but kind and status is zero.
    function rhp_pkg::rec_t make_record(rhp_pkg::kind_e kind, rhp_pkg::status_e st,
                                        bit with_hdr, logic [31:0] aux,
                                        int unsigned slot, int unsigned hsize,
                                        logic [7:0] pad);
      rhp_pkg::rec_t r;
      r = '0;
      r.kind   = kind;
      r.status = st;
      if (with_hdr) begin
        r.flags        = {hdr_bytes[0][5], hdr_bytes[0][4], hdr_bytes[1][7]};
        r.csrc_count   = hdr_bytes[0][3:0];
        r.payload_type = hdr_bytes[1][6:0];
        r.seq          = {hdr_bytes[2], hdr_bytes[3]};
        r.ts           = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
        r.ssrc         = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
        r.aux          = aux;
        r.slot         = 4'(slot);
        r.hsize        = rhp_pkg::HSIZE_W'(hsize);
        r.pad_len      = pad;
      end
      return r;
    endfunction

    // Advance the parser state by one accepted byte and queue the records it causes.
    function void note_byte(logic [7:0] b, logic lst);
      int unsigned      pos, cc, csrc_end, len, hs, ext_len;
      bit               ver_ok, has_ext, has_pad, with_hdr;
      rhp_pkg::status_e st;
      logic [31:0]      aux;
      logic [7:0]       pad_len;
      pos = byte_pos;
      if (pos < rhp_pkg::FIXED_HDR_BYTES) hdr_bytes[pos] = b;
      ver_ok   = hdr_bytes[0][7:6] == rhp_pkg::RTP_VERSION;
      cc       = hdr_bytes[0][3:0];
      has_ext  = hdr_bytes[0][4];
      has_pad  = hdr_bytes[0][5];
      csrc_end = rhp_pkg::FIXED_HDR_BYTES + 4 * cc;

      if (pos >= rhp_pkg::FIXED_HDR_BYTES && ver_ok) begin
        if (pos < csrc_end) begin
          word_acc = {word_acc[23:0], b};
          if (((pos - rhp_pkg::FIXED_HDR_BYTES) & 3) == 3)
            expected_records.push_back(make_record(rhp_pkg::KIND_CSRC, rhp_pkg::ST_OK,
                                                   1'b1, word_acc,
                                                   (pos - rhp_pkg::FIXED_HDR_BYTES) >> 2,
                                                   0, 8'd0));
        end else if (has_ext && pos < csrc_end + rhp_pkg::EXT_HDR_BYTES) begin
          word_acc = {word_acc[23:0], b};
          if (pos == csrc_end + rhp_pkg::EXT_HDR_BYTES - 1) ext_word = word_acc;
        end
      end

      if (lst) begin
        len      = (pos < pos_max) ? pos + 1 : pos_max;
        st       = rhp_pkg::ST_OK;
        hs       = rhp_pkg::FIXED_HDR_BYTES;
        aux      = '0;
        pad_len  = '0;
        with_hdr = 1'b1;
        if (len < rhp_pkg::FIXED_HDR_BYTES) begin
          st       = rhp_pkg::ST_SHORT;
          with_hdr = 1'b0;
        end else if (!ver_ok) begin
          st       = rhp_pkg::ST_BAD_VER;
          with_hdr = 1'b0;
        end else if (cc > 0 && len < csrc_end) begin
          st = rhp_pkg::ST_SHORT_CSRC;
        end else begin
          hs = csrc_end;
          if (has_ext) begin
            if (len < hs + rhp_pkg::EXT_HDR_BYTES) begin
              st = rhp_pkg::ST_SHORT_EXT_HDR;
            end else begin
              ext_len = ext_word[15:0];
              aux     = ext_word;
              hs     += rhp_pkg::EXT_HDR_BYTES;
              if (ext_len > 0 && len < hs + 4 * ext_len) st = rhp_pkg::ST_SHORT_EXT_DAT;
              else hs += 4 * ext_len;
            end
          end
          if (st == rhp_pkg::ST_OK && has_pad) pad_len = b;
        end
        expected_records.push_back(make_record(rhp_pkg::KIND_SUMMARY, st, with_hdr, aux,
                                               0, hs, pad_len));
        clear_packet();
      end else if (pos < pos_max) begin
        byte_pos = pos + 1;
      end
    endfunction

    function string fmt(rhp_pkg::rec_t r);
      return $sformatf({"kind=%0d st=%0d flags=%b cc=%0d pt=%0d seq=%h ts=%h ssrc=%h ",
                        "aux=%h slot=%0d hsize=%0d pad=%0d"},
                       r.kind, r.status, r.flags, r.csrc_count, r.payload_type, r.seq,
                       r.ts, r.ssrc, r.aux, r.slot, r.hsize, r.pad_len);
    endfunction

    function void flag_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Compare one record from the block against the oldest expectation.
    function void check_record(rhp_pkg::rec_t got);
      rhp_pkg::rec_t want;
      string         diff;
      if (expected_records.size() == 0) begin
        flag_failure($sformatf("%0t: unexpected record: %s", $realtime, fmt(got)));
        return;
      end
      want = expected_records.pop_front();
      diff = "";
      if (got.kind         !== want.kind)         diff = {diff, " kind"};
      if (got.status       !== want.status)       diff = {diff, " status"};
      if (got.flags        !== want.flags)        diff = {diff, " flags"};
      if (got.csrc_count   !== want.csrc_count)   diff = {diff, " csrc_count"};
      if (got.payload_type !== want.payload_type) diff = {diff, " payload_type"};
      if (got.seq          !== want.seq)          diff = {diff, " seq"};
      if (got.ts           !== want.ts)           diff = {diff, " ts"};
      if (got.ssrc         !== want.ssrc)         diff = {diff, " ssrc"};
      if (got.aux          !== want.aux)          diff = {diff, " aux"};
      if (got.slot         !== want.slot)         diff = {diff, " slot"};
      if (got.hsize        !== want.hsize)        diff = {diff, " hsize"};
      if (got.pad_len      !== want.pad_len)      diff = {diff, " pad_len"};
      if (diff != "")
        flag_failure($sformatf("%0t: record mismatch in%s\n  expected %s\n  actual   %s",
                               $realtime, diff, fmt(want), fmt(got)));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        record_kind_o;
  logic [2:0]  status_o;
  logic [2:0]  flag_bits_o;
  logic [3:0]  csrc_count_o;
  logic [6:0]  payload_type_o;
  logic [15:0] sequence_number_o;
  logic [31:0] time_stamp_o;
  logic [31:0] sync_source_o;
  logic [31:0] aux_word_o;
  logic [3:0]  csrc_slot_o;
  logic [18:0] header_size_o;
  logic [7:0]  padding_length_o;

  rtp_record_scoreboard records;
  int unsigned          cycles = 0;
  bit                   quiet  = 1'b0;  // set for the last part of the run: no idling

  rtp_header_parser #(
    .POSITION_BITS(POS_BITS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (record_kind_o),
    .status_o         (status_o),
    .flag_bits_o      (flag_bits_o),
    .csrc_count_o     (csrc_count_o),
    .payload_type_o   (payload_type_o),
    .sequence_number_o(sequence_number_o),
    .time_stamp_o     (time_stamp_o),
    .sync_source_o    (sync_source_o),
    .aux_word_o       (aux_word_o),
    .csrc_slot_o      (csrc_slot_o),
    .header_size_o    (header_size_o),
    .padding_length_o (padding_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Count cycles and stop a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Idle length for either side: a burst drawn now and then, but none in every
  // fourth stretch of the run and none at all once the run goes quiet.
  function automatic int unsigned idle_burst();
    if (quiet || (cycles / 256) % 4 == 0) return 0;
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: sample both channels at the clock edge, before any update lands.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rhp_pkg::rec_t seen;
    if (rst_ni && in_valid_i && !in_stall_o)
      records.note_byte(data_byte_i, last_byte_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.kind         = rhp_pkg::kind_e'(record_kind_o);
      seen.status       = rhp_pkg::status_e'(status_o);
      seen.flags        = flag_bits_o;
      seen.csrc_count   = csrc_count_o;
      seen.payload_type = payload_type_o;
      seen.seq          = sequence_number_o;
      seen.ts           = time_stamp_o;
      seen.ssrc         = sync_source_o;
      seen.aux          = aux_word_o;
      seen.slot         = csrc_slot_o;
      seen.hsize        = header_size_o;
      seen.pad_len      = padding_length_o;
      records.check_record(seen);
    end
  end

  // Hold the record channel off in random bursts; release it for good once quiet.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (quiet) hold = 0;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
        hold = idle_burst();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Packet construction
  // --------------------------------------------------------------------------
  // Fixed header from the given fields, then cc random CSRC words, then the
  // extension header carrying ext_len with only ext_words words of data behind
  // it, then payload, then padding whose final byte is the padding count.
  function automatic packet_t make_packet(logic [1:0] ver, logic pad, logic ext,
                                          logic [3:0] cc, logic mark, logic [6:0] pt,
                                          logic [15:0] seq, logic [31:0] ts,
                                          logic [31:0] ssrc, logic [15:0] ext_len,
                                          int unsigned ext_words, int unsigned payload_len,
                                          int unsigned pad_len);
    packet_t     q;
    logic [31:0] profile;
    q = {};
    q.push_back({ver, pad, ext, cc});
    q.push_back({mark, pt});
    q.push_back(seq[15:8]);
    q.push_back(seq[7:0]);
    for (int i = 3; i >= 0; i--) q.push_back(ts[8*i +: 8]);
    for (int i = 3; i >= 0; i--) q.push_back(ssrc[8*i +: 8]);
    repeat (4 * cc) q.push_back(8'($urandom));
    if (ext) begin
      profile = $urandom;
      q.push_back(profile[31:24]);
      q.push_back(profile[23:16]);
      q.push_back(ext_len[15:8]);
      q.push_back(ext_len[7:0]);
      repeat (4 * ext_words) q.push_back(8'($urandom));
    end
    repeat (payload_len) q.push_back(8'($urandom));
    if (pad_len > 0) begin
      repeat (pad_len - 1) q.push_back(8'($urandom));
      q.push_back(8'(pad_len));
    end
    return q;
  endfunction

  // Mostly well-formed packets with random content; the rest are truncated,
  // carry a wrong version, or are plain junk.
  function automatic packet_t random_packet();
    packet_t     q;
    int unsigned pick, n, pad_len, ext_words;
    logic [1:0]  ver;
    logic [3:0]  cc;
    logic [15:0] ext_len;
    logic        pad, ext;
    q    = {};
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      n = $urandom_range(1, 30);
      repeat (n) q.push_back(8'($urandom));
      return q;
    end
    ver = rhp_pkg::RTP_VERSION;
    if (pick < 15) begin
      ver = 2'($urandom_range(0, 2));
      if (ver == rhp_pkg::RTP_VERSION) ver = 2'd3;
    end
    cc        = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 2));
    ext       = $urandom_range(0, 1);
    ext_len   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 12))
                                            : 16'($urandom_range(0, 3));
    ext_words = ext_len;
    // Now and then claim a huge extension; hold the data short so it gets cut.
    if ($urandom_range(0, 29) == 0) begin
      ext_len   = 16'($urandom);
      ext_words = (ext_len > 4) ? 4 : ext_len;
    end
    pad     = $urandom_range(0, 1);
    pad_len = 0;
    if (pad)
      pad_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 4);
    q = make_packet(ver, pad, ext, cc, 1'($urandom), 7'($urandom), 16'($urandom), $urandom,
                    $urandom, ext_len, ext_words, $urandom_range(0, 16), pad_len);
    if (pick >= 15 && pick < 35) begin
      n = $urandom_range(1, q.size());
      q = q[0:n-1];
    end
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Byte driver
  // --------------------------------------------------------------------------
  // Drop valid for an idle burst if one is drawn, then present the beat and
  // hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = idle_burst();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    data_byte_i <= b;
    last_byte_i <= lst;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_packet(input packet_t q);
    foreach (q[i]) send_byte(q[i], i == q.size() - 1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    packet_t     pkt;
    int unsigned sent;
    records = new(POS_BITS);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single byte: too short.
    pkt = {8'h80};
    send_packet(pkt);
    // One byte short of a fixed header.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 0, 0, 0, 0, 7'h60, 16'h1234, 32'h0, 32'h0,
                      0, 0, 0, 0);
    pkt = pkt[0:10];
    send_packet(pkt);
    // Version 0 with every field zero.
    pkt = make_packet(2'd0, 0, 0, 0, 0, '0, '0, '0, '0, 0, 0, 0, 0);
    send_packet(pkt);
    // Version 3 with every flag and a full CSRC count: no CSRC records may appear.
    pkt = make_packet(2'd3, 1, 1, 4'hf, 1, '1, '1, '1, '1, 0, 0, 0, 0);
    pkt = pkt[0:19];
    send_packet(pkt);
    // Version 2, all fields zero, bare fixed header.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 0, 0, 0, 0, '0, '0, '0, '0, 0, 0, 0, 0);
    send_packet(pkt);
    // Fixed-header fields at their maximum with marker and padding.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 1, 0, 0, 1, '1, '1, '1, '1, 0, 0, 2, 3);
    send_packet(pkt);
    // Full CSRC list ending the packet: last CSRC and summary from one byte.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 0, 0, 4'hf, 0, 7'h11, 16'h0001, 32'h1, 32'h2,
                      0, 0, 0, 0);
    send_packet(pkt);
    // Short CSRC list, cut right at the fixed header.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 0, 0, 4'd2, 0, 7'h22, 16'h2, 32'h3, 32'h4,
                      0, 0, 0, 0);
    pkt = pkt[0:11];
    send_packet(pkt);
    // Short CSRC list after one complete word.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 1, 0, 4'd3, 1, 7'h33, 16'h3, 32'h5, 32'h6,
                      0, 0, 0, 0);
    pkt = pkt[0:17];
    send_packet(pkt);
    // Short extension header.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 0, 1, 4'd1, 0, 7'h44, 16'h4, 32'h7, 32'h8,
                      16'd1, 1, 0, 0);
    pkt = pkt[0:17];
    send_packet(pkt);
    // Short extension data.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 1, 1, 4'd0, 0, 7'h55, 16'h5, 32'h9, 32'ha,
                      16'd2, 2, 0, 0);
    pkt = pkt[0:22];
    send_packet(pkt);
    // Extensions that fit: zero length, then one word with payload and padding.
    pkt = make_packet(rhp_pkg::RTP_VERSION, 0, 1, 4'd0, 1, 7'h66, 16'h6, 32'hb, 32'hc,
                      16'd0, 0, 0, 0);
    send_packet(pkt);
    pkt = make_packet(rhp_pkg::RTP_VERSION, 1, 1, 4'd2, 0, 7'h77, 16'h7, 32'hd, 32'he,
                      16'd1, 1, 3, 2);
    send_packet(pkt);

    // Random traffic with idling on both sides.
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      pkt   = random_packet();
      sent += pkt.size();
      send_packet(pkt);
    end

    // Last part: no idling. Finish with a packet that claims the largest
    // extension length and carries only a few words of it.
    quiet = 1'b1;
    repeat (QUIET_PKTS) begin
      pkt = random_packet();
      send_packet(pkt);
    end
    pkt = make_packet(rhp_pkg::RTP_VERSION, 1, 1, 4'd0, 1, 7'h7f, 16'hbeef, $urandom,
                      $urandom, 16'hffff, 4, 0, 0);
    send_packet(pkt);
    in_valid_i <= 1'b0;

    // Drain the expected records, then give the pipeline time to show strays.
    while (records.expected_records.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (records.failures == 0 && records.expected_records.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
